// File: rtl/core/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared codes and controller/datapath interface types of the sorted table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_UPDATE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_EXISTS = 2'd1,
        STATUS_ABSENT = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    // table change that an operation makes once the search is done
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_UPDATE = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_NARROW,
        ST_CHECK,
        ST_MOVE,
        ST_SHIFT_WR,
        ST_COMMIT,
        ST_REPLY
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_mid;
        logic narrow;
        logic rd_pos;
        logic check;
        logic shift_rd;
        logic shift_wr;
        logic commit;
        logic reply;
    } cmd_t;

    typedef struct packed {
        logic search_open;
        logic shift_more;
        act_t act;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/skvt_ctrl.sv
// ----------------------------------------------------------------------------
// skvt_ctrl
// Sequencer for search, shift and commit of one table operation at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire skvt_pkg::sts_t sts,
    output skvt_pkg::cmd_t      cmd
);

    skvt_pkg::state_t state_reg;
    skvt_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = skvt_pkg::ST_SEARCH;
                end
            end
            skvt_pkg::ST_SEARCH:
            begin
                if (sts.search_open)
                begin
                    state_next = skvt_pkg::ST_NARROW;
                end
                else
                begin
                    state_next = skvt_pkg::ST_CHECK;
                end
            end
            skvt_pkg::ST_NARROW:
            begin
                state_next = skvt_pkg::ST_SEARCH;
            end
            skvt_pkg::ST_CHECK:
            begin
                case (sts.act)
                    skvt_pkg::ACT_INSERT: state_next = skvt_pkg::ST_MOVE;
                    skvt_pkg::ACT_ERASE:  state_next = skvt_pkg::ST_MOVE;
                    skvt_pkg::ACT_UPDATE: state_next = skvt_pkg::ST_COMMIT;
                    default:              state_next = skvt_pkg::ST_REPLY;
                endcase
            end
            skvt_pkg::ST_MOVE:
            begin
                if (sts.shift_more)
                begin
                    state_next = skvt_pkg::ST_SHIFT_WR;
                end
                else
                begin
                    state_next = skvt_pkg::ST_COMMIT;
                end
            end
            skvt_pkg::ST_SHIFT_WR:
            begin
                state_next = skvt_pkg::ST_MOVE;
            end
            skvt_pkg::ST_COMMIT:
            begin
                state_next = skvt_pkg::ST_REPLY;
            end
            skvt_pkg::ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = skvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            skvt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            skvt_pkg::ST_SEARCH:
            begin
                cmd.rd_mid = sts.search_open;
                cmd.rd_pos = !sts.search_open;
            end
            skvt_pkg::ST_NARROW:   cmd.narrow   = 1'b1;
            skvt_pkg::ST_CHECK:    cmd.check    = 1'b1;
            skvt_pkg::ST_MOVE:     cmd.shift_rd = sts.shift_more;
            skvt_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
            skvt_pkg::ST_COMMIT:   cmd.commit   = 1'b1;
            skvt_pkg::ST_REPLY:    cmd.reply    = out_free;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.reply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skvt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/skvt_dpath.sv
// ----------------------------------------------------------------------------
// skvt_dpath
// Entry memory, binary search bounds, shift pointer and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module skvt_dpath #(
    parameter int CAPACITY  = 256,
    parameter int DATA_BITS = 64,
    parameter int KEY_BITS  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire skvt_pkg::cmd_t     cmd,
    output skvt_pkg::sts_t          sts,
    input  wire logic        [1:0]  kind,
    input  wire logic signed [31:0] key,
    input  wire logic        [63:0] value,
    output logic             [1:0]  status,
    output logic                    found,
    output logic             [63:0] data_out,
    output logic             [8:0]  position,
    output logic             [8:0]  entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_BITS + DATA_BITS;
    localparam logic [CW-1:0] CountMax = CW'(CAPACITY);
    localparam logic [CW-1:0] CountOne = CW'(1);

    logic [EW-1:0] mem [CAPACITY];

    skvt_pkg::kind_t          kind_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic [DATA_BITS-1:0]     val_reg;
    logic [CW-1:0]            lo_reg;
    logic [CW-1:0]            hi_reg;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            idx_reg;
    logic [AW-1:0]            mid_reg;
    logic [EW-1:0]            rd_data_reg;
    logic                     hit_reg;
    skvt_pkg::act_t           act_reg;
    skvt_pkg::status_t        status_reg;
    logic [DATA_BITS-1:0]     data_reg;

    logic [1:0]               status_out_reg;
    logic                     found_out_reg;
    logic [DATA_BITS-1:0]     data_out_reg;
    logic [CW-1:0]            pos_out_reg;
    logic [CW-1:0]            count_out_reg;

    logic signed [63:0]       key_wide;
    logic [CW:0]              bound_sum;
    logic [AW-1:0]            mid;
    logic signed [KEY_BITS-1:0] rd_key;
    logic [DATA_BITS-1:0]     rd_val;
    logic                     hit_now;
    logic                     full;
    skvt_pkg::act_t           act_now;
    skvt_pkg::status_t        status_now;
    logic [CW-1:0]            idx_dec;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;

    assign key_wide  = 64'(key);
    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = bound_sum[AW:1];
    assign rd_key    = rd_data_reg[EW-1:DATA_BITS];
    assign rd_val    = rd_data_reg[DATA_BITS-1:0];
    assign hit_now   = (lo_reg < count_reg) && (rd_key == key_reg);
    assign full      = (count_reg == CountMax);
    assign idx_dec   = idx_reg - CountOne;

    always_comb
    begin
        act_now    = skvt_pkg::ACT_NONE;
        status_now = hit_now ? skvt_pkg::STATUS_OK : skvt_pkg::STATUS_ABSENT;
        case (kind_reg)
            skvt_pkg::KIND_INSERT:
            begin
                if (hit_now)
                begin
                    status_now = skvt_pkg::STATUS_EXISTS;
                end
                else if (full)
                begin
                    status_now = skvt_pkg::STATUS_FULL;
                end
                else
                begin
                    status_now = skvt_pkg::STATUS_OK;
                    act_now    = skvt_pkg::ACT_INSERT;
                end
            end
            skvt_pkg::KIND_ERASE:
            begin
                if (hit_now)
                begin
                    act_now = skvt_pkg::ACT_ERASE;
                end
            end
            skvt_pkg::KIND_UPDATE:
            begin
                if (hit_now)
                begin
                    act_now = skvt_pkg::ACT_UPDATE;
                end
            end
            default:
            begin
                act_now = skvt_pkg::ACT_NONE;
            end
        endcase
    end

    always_comb
    begin
        sts.search_open = (lo_reg < hi_reg);
        sts.act         = act_now;
        case (act_reg)
            skvt_pkg::ACT_INSERT: sts.shift_more = (idx_reg > lo_reg);
            skvt_pkg::ACT_ERASE:  sts.shift_more = (idx_reg < count_reg);
            default:              sts.shift_more = 1'b0;
        endcase
    end

    // one read and one write port; insert shifts upward, erase downward
    always_comb
    begin
        rd_en   = cmd.rd_mid || cmd.rd_pos || cmd.shift_rd;
        rd_addr = lo_reg[AW-1:0];
        if (cmd.rd_mid)
        begin
            rd_addr = mid;
        end
        else if (cmd.shift_rd)
        begin
            rd_addr = (act_reg == skvt_pkg::ACT_INSERT) ? idx_dec[AW-1:0]
                                                        : idx_reg[AW-1:0];
        end

        wr_en   = cmd.shift_wr ||
                  (cmd.commit && (act_reg == skvt_pkg::ACT_INSERT ||
                                  act_reg == skvt_pkg::ACT_UPDATE));
        wr_addr = lo_reg[AW-1:0];
        wr_data = {key_reg, val_reg};
        if (cmd.shift_wr)
        begin
            wr_addr = (act_reg == skvt_pkg::ACT_INSERT) ? idx_reg[AW-1:0]
                                                        : idx_dec[AW-1:0];
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.commit)
        begin
            case (act_reg)
                skvt_pkg::ACT_INSERT: count_next = count_reg + CountOne;
                skvt_pkg::ACT_ERASE:  count_next = count_reg - CountOne;
                default:              count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= skvt_pkg::kind_t'(kind);
            key_reg  <= key_wide[KEY_BITS-1:0];
            val_reg  <= value[DATA_BITS-1:0];
            lo_reg   <= '0;
            hi_reg   <= count_reg;
        end
        if (cmd.rd_mid)
        begin
            mid_reg <= mid;
        end
        if (cmd.narrow)
        begin
            if (rd_key < key_reg)
            begin
                lo_reg <= CW'(mid_reg) + CountOne;
            end
            else
            begin
                hi_reg <= CW'(mid_reg);
            end
        end
        if (cmd.check)
        begin
            hit_reg    <= hit_now;
            act_reg    <= act_now;
            status_reg <= status_now;
            data_reg   <= hit_now ? rd_val : '0;
            idx_reg    <= (act_now == skvt_pkg::ACT_INSERT) ? count_reg
                                                            : lo_reg + CountOne;
        end
        if (cmd.shift_wr)
        begin
            idx_reg <= (act_reg == skvt_pkg::ACT_INSERT) ? idx_dec
                                                         : idx_reg + CountOne;
        end
        if (cmd.reply)
        begin
            status_out_reg <= status_reg;
            found_out_reg  <= hit_reg;
            data_out_reg   <= data_reg;
            pos_out_reg    <= lo_reg;
            count_out_reg  <= count_reg;
        end
    end

    assign status      = status_out_reg;
    assign found       = found_out_reg;
    assign data_out    = 64'(data_out_reg);
    assign position    = 9'(pos_out_reg);
    assign entry_count = 9'(count_out_reg);

endmodule

`default_nettype wire

// File: rtl/core/sorted_key_value_table_top.sv
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// Bounded key/value map kept in ascending signed-key order in one memory.
// ----------------------------------------------------------------------------
// An operation (kind, key, value) is a transfer on the in_valid/in_ready
// channel; each one gives exactly one result (status, found, data_out,
// position, entry_count) as a transfer on the out_valid/out_ready channel.
// One operation is worked on at a time; in_ready is high while the sequencer
// is idle, also while an earlier result still waits in the output register.
// The position is found by a binary search over the n stored entries, at most
// ceil(log2(n+1)) steps, each of them a registered memory read and a narrowing
// of the bounds. Insert and erase move the later entries one at a time through
// the single read and write port. The next transfer in can be taken as early as
// the cycle in which out_valid rises. A finished result waits in REPLY while the
// output register is still held by a stalled receiver; nothing is dropped.
// Reset clears the entry count and the handshake state at once; the entry
// memory itself needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table_top #(
    parameter int CAPACITY  = 256,
    parameter int DATA_BITS = 64,
    parameter int KEY_BITS  = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic        [1:0]  kind,
    input  wire logic signed [31:0] key,
    input  wire logic        [63:0] value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic             [1:0]  status,
    output logic                    found,
    output logic             [63:0] data_out,
    output logic             [8:0]  position,
    output logic             [8:0]  entry_count
);

    skvt_pkg::cmd_t cmd;
    skvt_pkg::sts_t sts;

    skvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    skvt_dpath #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS),
        .KEY_BITS  (KEY_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .key         (key),
        .value       (value),
        .status      (status),
        .found       (found),
        .data_out    (data_out),
        .position    (position),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire
